### rtl/bci_pkg.sv
package bci_pkg;

    localparam int QTIME_W = 27;
    localparam int PTIME_W = 10;
    localparam int PVAL_W = 16;
    localparam int TVAL_W = 24;
    localparam int CURVE_W = 2;
    localparam int PIDX_W = 4;
    localparam int CFG_W = 3;
    localparam int RESULT_LIMIT = 4;
    localparam int FRAC_W = 8;

    localparam int MUL_A_W = PVAL_W + 1;
    localparam int MUL_B_W = QTIME_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W = MUL_P_W + 1;

    localparam int DIVN_W = ACC_W + FRAC_W;
    localparam int DIVD_W = 16;
    localparam int STEP_W = 6;

    localparam logic [TVAL_W-1:0] TV_MAX = {1'b0, {(TVAL_W-1){1'b1}}};
    localparam logic [TVAL_W-1:0] TV_MIN = {1'b1, {(TVAL_W-1){1'b0}}};

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic done;
    } div_rsp_t;

endpackage

### rtl/breakpoint_curve_interpolator.sv
// Breakpoint curve interpolator.
// A word is accepted when start is high and busy is low. With mode low the
// word loads one breakpoint into a curve; it gives no
// result. With mode high the word queries every curve in use at a time in
// milliseconds, and busy stays high until the last result has been issued.
// Each result is shown for one cycle with result_valid high, curve by curve
// in ascending order, and last marks the final one of a query.
// A query first turns the time into minutes by a reciprocal multiplication,
// then for each curve passes the breakpoints in a search, reads the segment
// end points, sums two products and divides the sum by the time span. A
// curve with fewer than two points skips the search, and a time past the
// last point ends that curve after the search. The shared divider retires
// one quotient bit per cycle over 54 steps for the segment division. Each
// result is registered and appears in the cycle after its curve ends, and
// busy drops in the cycle that shows the last result.
// cfg_write_en writes curves_in_use; the user must write it only while the
// block is idle; the block itself does not enforce it. Reset clears all
// point counts and sets curves_in_use to one; breakpoints are undefined until loaded.
// The receiver cannot stall: results are not held and must be taken at once.
module breakpoint_curve_interpolator #(
    parameter int NUM_CURVES = 4,
    parameter int MAX_POINTS = 16,
    parameter int MS_PER_MINUTE = 60000
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 mode,
    input  logic [bci_pkg::CURVE_W-1:0]          curve_index,
    input  logic [bci_pkg::PIDX_W-1:0]           point_index,
    input  logic [bci_pkg::PTIME_W-1:0]          point_time_min,
    input  logic signed [bci_pkg::PVAL_W-1:0]    point_value,
    input  logic [bci_pkg::QTIME_W-1:0]          query_time_ms,
    input  logic                                 cfg_write_en,
    input  logic [bci_pkg::CFG_W-1:0]            cfg_write_data,
    output logic                                 result_valid,
    output logic [bci_pkg::CURVE_W-1:0]          result_curve,
    output logic signed [bci_pkg::TVAL_W-1:0]    target_value,
    output logic                                 clamped_flag,
    output logic                                 last
);
    import bci_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int NLIM = (NUM_CURVES < RESULT_LIMIT) ? NUM_CURVES : RESULT_LIMIT;
    localparam int RSHIFT = QTIME_W + $clog2(MS_PER_MINUTE);
    localparam int RECIP_W = QTIME_W + 2;
    localparam longint RECIP = ((longint'(1) <<< RSHIFT) + longint'(MS_PER_MINUTE)
                                - longint'(1)) / longint'(MS_PER_MINUTE);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_MDIV   = 11'b00000000010,
        S_CSTART = 11'b00000000100,
        S_FEW    = 11'b00000001000,
        S_SRCH   = 11'b00000010000,
        S_GETP0  = 11'b00000100000,
        S_MUL0   = 11'b00001000000,
        S_MUL1   = 11'b00010000000,
        S_SUM    = 11'b00100000000,
        S_DSTART = 11'b01000000000,
        S_DIV    = 11'b10000000000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CFG_W-1:0]         cfg_reg;
    logic [CURVE_W-1:0]       last_reg;
    logic [CURVE_W-1:0]       last_next;
    logic [CURVE_W-1:0]       cur_reg;
    logic [CURVE_W-1:0]       cur_next;
    logic [QTIME_W-1:0]       qtime_reg;
    logic [QTIME_W-1:0]       qtime_next;
    logic [QTIME_W-1:0]       m_reg;
    logic [QTIME_W-1:0]       m_next;
    logic                     rnz_reg;
    logic                     rnz_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [CNT_W-1:0]         pidx_reg;
    logic [CNT_W-1:0]         pidx_next;
    logic [PTIME_W-1:0]       t0_reg;
    logic [PTIME_W-1:0]       t0_next;
    logic [PTIME_W-1:0]       t1_reg;
    logic [PTIME_W-1:0]       t1_next;
    logic signed [PVAL_W-1:0] v0_reg;
    logic signed [PVAL_W-1:0] v0_next;
    logic signed [PVAL_W-1:0] v1_reg;
    logic signed [PVAL_W-1:0] v1_next;
    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     neg_reg;
    logic                     neg_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [CURVE_W-1:0]       out_curve_reg;
    logic [CURVE_W-1:0]       out_curve_next;
    logic [TVAL_W-1:0]        out_val_reg;
    logic [TVAL_W-1:0]        out_val_next;
    logic                     out_flag_reg;
    logic                     out_flag_next;
    logic                     out_last_reg;
    logic                     out_last_next;

    logic                     store_wr_en;
    logic [CNT_W-1:0]         rd_point;
    logic [CNT_W-1:0]         store_count;
    logic [PTIME_W-1:0]       rd_time;
    logic signed [PVAL_W-1:0] rd_value;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;
    logic [DIVN_W-1:0]        div_dividend;
    logic [DIVD_W-1:0]        div_divisor;
    logic [DIVN_W-1:0]        div_quot;

    logic [CFG_W-1:0]         n_curves;
    logic                     adv;
    logic [QTIME_W+RECIP_W-1:0] m_prod;
    logic [QTIME_W-1:0]       m_back;
    logic                     dt_neg;
    logic [PTIME_W-1:0]       dt_mag;
    logic signed [PTIME_W:0]  dt_s;
    logic signed [MUL_A_W-1:0] dv_s;
    logic signed [MUL_B_W-1:0] x_s;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic [ACC_W-1:0]         acc_mag;
    logic                     fin;
    logic [TVAL_W-1:0]        fin_val;
    logic                     fin_flag;

    bci_store #(
        .NUM_CURVES(NUM_CURVES),
        .MAX_POINTS(MAX_POINTS)
    ) u_store (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(store_wr_en),
        .wr_curve(curve_index),
        .wr_point(point_index),
        .wr_time(point_time_min),
        .wr_value(point_value),
        .rd_curve(cur_reg),
        .rd_point(rd_point),
        .count(store_count),
        .rd_time(rd_time),
        .rd_value(rd_value)
    );

    bci_divider u_divider (
        .clk(clk),
        .rst_n(rst_n),
        .req(div_req),
        .dividend(div_dividend),
        .divisor(div_divisor),
        .rsp(div_rsp),
        .quotient(div_quot)
    );

    always_comb
    begin
        n_curves = (cfg_reg == '0) ? CFG_W'(1) : cfg_reg;
        if (32'(n_curves) > NLIM)
        begin
            n_curves = CFG_W'(NLIM);
        end
    end

    // The reciprocal is rounded up so that the product gives the exact
    // quotient for every 27-bit time.
    assign m_prod = query_time_ms * RECIP_W'(RECIP);
    assign m_back = m_reg * QTIME_W'(MS_PER_MINUTE);

    // A point is passed while its time in milliseconds lies below the query.
    assign adv = (QTIME_W'(rd_time) < m_reg) || ((QTIME_W'(rd_time) == m_reg) && rnz_reg);
    assign dt_neg = (t1_reg < t0_reg);
    assign dt_mag = dt_neg ? (t0_reg - t1_reg) : (t1_reg - t0_reg);
    assign dt_s = $signed({1'b0, t1_reg}) - $signed({1'b0, t0_reg});
    assign dv_s = MUL_A_W'(v1_reg) - MUL_A_W'(v0_reg);
    assign x_s = $signed({1'b0, m_reg}) - $signed(MUL_B_W'(t0_reg));
    assign mul_p = mul_a * mul_b;
    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    always_comb
    begin
        state_next = state_reg;
        last_next = last_reg;
        cur_next = cur_reg;
        qtime_next = qtime_reg;
        m_next = m_reg;
        rnz_next = rnz_reg;
        cnt_next = cnt_reg;
        pidx_next = pidx_reg;
        t0_next = t0_reg;
        t1_next = t1_reg;
        v0_next = v0_reg;
        v1_next = v1_reg;
        prod_next = prod_reg;
        acc_next = acc_reg;
        neg_next = neg_reg;
        out_valid_next = 1'b0;
        out_curve_next = out_curve_reg;
        out_val_next = out_val_reg;
        out_flag_next = out_flag_reg;
        out_last_next = out_last_reg;
        store_wr_en = 1'b0;
        rd_point = '0;
        div_req = '0;
        div_dividend = '0;
        div_divisor = '0;
        mul_a = '0;
        mul_b = '0;
        fin = 1'b0;
        fin_val = '0;
        fin_flag = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!mode)
                    begin
                        store_wr_en = 1'b1;
                    end
                    else
                    begin
                        qtime_next = query_time_ms;
                        m_next = QTIME_W'(m_prod >> RSHIFT);
                        last_next = CURVE_W'(n_curves - CFG_W'(1));
                        state_next = S_MDIV;
                    end
                end
            end
            S_MDIV:
            begin
                rnz_next = (m_back != qtime_reg);
                cur_next = '0;
                state_next = S_CSTART;
            end
            S_CSTART:
            begin
                cnt_next = store_count;
                pidx_next = CNT_W'(1);
                if (store_count < CNT_W'(2))
                begin
                    rd_point = '0;
                    state_next = S_FEW;
                end
                else
                begin
                    rd_point = CNT_W'(1);
                    state_next = S_SRCH;
                end
            end
            S_FEW:
            begin
                fin = 1'b1;
                fin_flag = 1'b1;
                fin_val = (cnt_reg == CNT_W'(1)) ? {rd_value, FRAC_W'(0)} : '0;
            end
            S_SRCH:
            begin
                if (adv)
                begin
                    if (pidx_reg + CNT_W'(1) >= cnt_reg)
                    begin
                        fin = 1'b1;
                        fin_flag = 1'b1;
                        fin_val = {rd_value, FRAC_W'(0)};
                    end
                    else
                    begin
                        pidx_next = pidx_reg + CNT_W'(1);
                        rd_point = pidx_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    t1_next = rd_time;
                    v1_next = rd_value;
                    rd_point = pidx_reg - CNT_W'(1);
                    state_next = S_GETP0;
                end
            end
            S_GETP0:
            begin
                t0_next = rd_time;
                v0_next = rd_value;
                state_next = S_MUL0;
            end
            S_MUL0:
            begin
                if (t0_reg == t1_reg)
                begin
                    fin = 1'b1;
                    fin_flag = 1'b1;
                    fin_val = {v1_reg, FRAC_W'(0)};
                end
                else
                begin
                    mul_a = MUL_A_W'(v0_reg);
                    mul_b = MUL_B_W'(dt_s);
                    prod_next = mul_p;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                acc_next = ACC_W'(prod_reg);
                mul_a = dv_s;
                mul_b = x_s;
                prod_next = mul_p;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                div_req.start = 1'b1;
                div_req.steps = STEP_W'(DIVN_W);
                div_dividend = {acc_mag, FRAC_W'(0)};
                div_divisor = DIVD_W'(dt_mag);
                neg_next = acc_reg[ACC_W-1] ^ dt_neg;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    fin = 1'b1;
                    if (neg_reg)
                    begin
                        fin_val = (div_quot > DIVN_W'(TV_MIN)) ? TV_MIN :
                                  (TVAL_W'(0) - div_quot[TVAL_W-1:0]);
                    end
                    else
                    begin
                        fin_val = (div_quot > DIVN_W'(TV_MAX)) ? TV_MAX :
                                  div_quot[TVAL_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            out_valid_next = 1'b1;
            out_curve_next = cur_reg;
            out_val_next = fin_val;
            out_flag_next = fin_flag;
            out_last_next = (cur_reg == last_reg);
            if (cur_reg == last_reg)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                cur_next = cur_reg + CURVE_W'(1);
                state_next = S_CSTART;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cfg_reg <= CFG_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                cfg_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        cur_reg <= cur_next;
        qtime_reg <= qtime_next;
        m_reg <= m_next;
        rnz_reg <= rnz_next;
        cnt_reg <= cnt_next;
        pidx_reg <= pidx_next;
        t0_reg <= t0_next;
        t1_reg <= t1_next;
        v0_reg <= v0_next;
        v1_reg <= v1_next;
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        neg_reg <= neg_next;
        out_curve_reg <= out_curve_next;
        out_val_reg <= out_val_next;
        out_flag_reg <= out_flag_next;
        out_last_reg <= out_last_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result_curve = out_curve_reg;
    assign target_value = out_val_reg;
    assign clamped_flag = out_flag_reg;
    assign last = out_last_reg;

endmodule

### rtl/bci_divider.sv
module bci_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bci_pkg::div_req_t            req,
    input  logic [bci_pkg::DIVN_W-1:0]   dividend,
    input  logic [bci_pkg::DIVD_W-1:0]   divisor,
    output bci_pkg::div_rsp_t            rsp,
    output logic [bci_pkg::DIVN_W-1:0]   quotient
);
    import bci_pkg::*;

    logic              active_reg;
    logic              active_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic [DIVN_W-1:0] qr_reg;
    logic [DIVN_W-1:0] qr_next;
    logic [DIVD_W-1:0] rem_reg;
    logic [DIVD_W-1:0] rem_next;
    logic [DIVD_W-1:0] d_reg;
    logic [DIVD_W-1:0] d_next;
    logic [DIVD_W:0]   trial;
    logic              fits;

    // One quotient bit per cycle; the dividend shifts out of the top as the
    // quotient shifts in at the bottom.
    always_comb
    begin
        trial = {rem_reg, qr_reg[DIVN_W-1]};
        fits = (trial >= {1'b0, d_reg});
        active_next = active_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        qr_next = qr_reg;
        rem_next = rem_reg;
        d_next = d_reg;
        if (req.start)
        begin
            active_next = 1'b1;
            cnt_next = req.steps;
            qr_next = dividend;
            rem_next = '0;
            d_next = divisor;
        end
        else if (active_reg)
        begin
            qr_next = {qr_reg[DIVN_W-2:0], fits};
            rem_next = fits ? DIVD_W'(trial - {1'b0, d_reg}) : trial[DIVD_W-1:0];
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                active_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qr_reg <= qr_next;
        rem_reg <= rem_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign quotient = qr_reg;

endmodule

### rtl/bci_store.sv
module bci_store #(
    parameter int NUM_CURVES = 4,
    parameter int MAX_POINTS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [bci_pkg::CURVE_W-1:0]          wr_curve,
    input  logic [bci_pkg::PIDX_W-1:0]           wr_point,
    input  logic [bci_pkg::PTIME_W-1:0]          wr_time,
    input  logic signed [bci_pkg::PVAL_W-1:0]    wr_value,
    input  logic [bci_pkg::CURVE_W-1:0]          rd_curve,
    input  logic [$clog2(MAX_POINTS+1)-1:0]      rd_point,
    output logic [$clog2(MAX_POINTS+1)-1:0]      count,
    output logic [bci_pkg::PTIME_W-1:0]          rd_time,
    output logic signed [bci_pkg::PVAL_W-1:0]    rd_value
);
    import bci_pkg::*;

    localparam int DEPTH = NUM_CURVES * MAX_POINTS;
    localparam int AW = $clog2(DEPTH);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CI_W = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1;

    logic [PTIME_W-1:0]       bp_time_reg [DEPTH];
    logic signed [PVAL_W-1:0] bp_value_reg [DEPTH];
    logic [PTIME_W-1:0]       rd_time_reg;
    logic signed [PVAL_W-1:0] rd_value_reg;
    logic [CNT_W-1:0]         count_reg [NUM_CURVES];
    logic                     wr_ok;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;

    assign wr_ok = wr_en && (32'(wr_curve) < NUM_CURVES) && (32'(wr_point) < MAX_POINTS);
    assign wr_addr = AW'(int'(wr_curve) * MAX_POINTS + int'(wr_point));
    assign rd_addr = AW'(int'(rd_curve) * MAX_POINTS + int'(rd_point));

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            bp_time_reg[wr_addr] <= wr_time;
            bp_value_reg[wr_addr] <= wr_value;
        end
        rd_time_reg <= bp_time_reg[rd_addr];
        rd_value_reg <= bp_value_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CURVES; k++)
            begin
                count_reg[k] <= '0;
            end
        end
        else if (wr_ok)
        begin
            count_reg[CI_W'(wr_curve)] <= CNT_W'(int'(wr_point) + 1);
        end
    end

    assign count = count_reg[CI_W'(rd_curve)];
    assign rd_time = rd_time_reg;
    assign rd_value = rd_value_reg;

endmodule

### tb/breakpoint_curve_interpolator_test.sv
`timescale 1ns / 100ps

localparam logic MODE_LOAD = 1'b0;
localparam logic MODE_QUERY = 1'b1;
localparam int CURVE_COUNT = 4;
localparam int KNOTS_PER_CURVE = 16;
localparam longint MS_PER_MIN = 60000;
localparam longint VALUE_MAX = 8388607;
localparam longint VALUE_MIN = -8388608;

class curve_scoreboard;

    typedef struct {
        logic [bci_pkg::CURVE_W-1:0]       curve;
        logic signed [bci_pkg::TVAL_W-1:0] value;
        logic                              clamped;
        logic                              last_word;
    } curve_result_t;

    logic [bci_pkg::PTIME_W-1:0]       knot_time [CURVE_COUNT*KNOTS_PER_CURVE];
    logic signed [bci_pkg::PVAL_W-1:0] knot_value [CURVE_COUNT*KNOTS_PER_CURVE];
    int                                knot_count [CURVE_COUNT];
    logic [bci_pkg::CFG_W-1:0]         curves_cfg;
    curve_result_t                     pending_results [$];
    int                                errors;

    function new();
        for (int k = 0; k < CURVE_COUNT*KNOTS_PER_CURVE; k++)
        begin
            knot_time[k] = '0;
            knot_value[k] = '0;
        end
        for (int c = 0; c < CURVE_COUNT; c++)
        begin
            knot_count[c] = 0;
        end
        curves_cfg = 3'd1;
        errors = 0;
    endfunction

    function void set_curves(logic [bci_pkg::CFG_W-1:0] v);
        curves_cfg = v;
    endfunction

    function void interpolate(int c, longint q, output longint val, output logic flag);
        int base;
        int cnt;
        int i;
        longint t0;
        longint t1;
        longint v0;
        longint v1;
        longint dt;
        longint x;
        longint num;
        base = c * KNOTS_PER_CURVE;
        cnt = knot_count[c];
        i = 1;
        flag = 1'b1;
        if (cnt < 2)
        begin
            val = (cnt == 1) ? longint'(knot_value[base]) * 256 : 0;
            return;
        end
        while (i < cnt && longint'(knot_time[base+i]) * MS_PER_MIN < q)
        begin
            i++;
        end
        if (i >= cnt)
        begin
            val = longint'(knot_value[base+cnt-1]) * 256;
            return;
        end
        t0 = longint'(knot_time[base+i-1]);
        t1 = longint'(knot_time[base+i]);
        v0 = longint'(knot_value[base+i-1]);
        v1 = longint'(knot_value[base+i]);
        dt = t1 - t0;
        if (dt == 0)
        begin
            val = v1 * 256;
            return;
        end
        x = q / MS_PER_MIN - t0;
        num = (v0 * dt + (v1 - v0) * x) * 256;
        if (dt < 0)
        begin
            dt = -dt;
            num = -num;
        end
        val = num / dt;
        if (val > VALUE_MAX)
            val = VALUE_MAX;
        if (val < VALUE_MIN)
            val = VALUE_MIN;
        flag = 1'b0;
    endfunction

    function void note_word(logic m, logic [1:0] c, logic [3:0] p, logic [9:0] t,
                            logic signed [15:0] v, logic [26:0] q);
        int n;
        int idx;
        longint val;
        logic flag;
        curve_result_t r;
        if (m == MODE_LOAD)
        begin
            idx = int'(c) * KNOTS_PER_CURVE + int'(p);
            knot_time[idx] = t;
            knot_value[idx] = v;
            knot_count[c] = int'(p) + 1;
            return;
        end
        n = int'(curves_cfg);
        if (n == 0)
            n = 1;
        if (n > CURVE_COUNT)
            n = CURVE_COUNT;
        for (int k = 0; k < n; k++)
        begin
            interpolate(k, longint'(q), val, flag);
            r.curve = k[1:0];
            r.value = val[23:0];
            r.clamped = flag;
            r.last_word = (k == n - 1);
            pending_results = {pending_results, r};
        end
    endfunction

    task report(string what);
        $display("ERROR at %0t: %s", $realtime, what);
        errors++;
    endtask

    task check(logic [1:0] curve, logic signed [23:0] value, logic clamped,
               logic last_word);
        curve_result_t want;
        if (pending_results.size() == 0)
        begin
            report($sformatf("result for curve %0d with nothing expected", curve));
            return;
        end
        want = pending_results.pop_front();
        if (curve !== want.curve)
            report($sformatf("curve %0d, expected %0d", curve, want.curve));
        if (value !== want.value)
            report($sformatf("curve %0d value %0d, expected %0d", want.curve, value,
                             want.value));
        if (clamped !== want.clamped)
            report($sformatf("curve %0d clamped %b, expected %b", want.curve, clamped,
                             want.clamped));
        if (last_word !== want.last_word)
            report($sformatf("curve %0d last %b, expected %b", want.curve, last_word,
                             want.last_word));
    endtask

endclass

module breakpoint_curve_interpolator_test;

    localparam int STALL_LIMIT = 5000;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic                                 mode = MODE_LOAD;
    logic [bci_pkg::CURVE_W-1:0]          curve_index = '0;
    logic [bci_pkg::PIDX_W-1:0]           point_index = '0;
    logic [bci_pkg::PTIME_W-1:0]          point_time_min = '0;
    logic signed [bci_pkg::PVAL_W-1:0]    point_value = '0;
    logic [bci_pkg::QTIME_W-1:0]          query_time_ms = '0;
    logic                                 cfg_write_en = 1'b0;
    logic [bci_pkg::CFG_W-1:0]            cfg_write_data = '0;
    logic                                 result_valid;
    logic [bci_pkg::CURVE_W-1:0]          result_curve;
    logic signed [bci_pkg::TVAL_W-1:0]    target_value;
    logic                                 clamped_flag;
    logic                                 last;

    curve_scoreboard board;
    logic [KNOTS_PER_CURVE-1:0] written_knots [CURVE_COUNT] = '{default: '0};
    int sender_idle_pct = 0;
    int words_sent = 0;
    int stall_cycles = 0;

    breakpoint_curve_interpolator uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .curve_index(curve_index),
        .point_index(point_index),
        .point_time_min(point_time_min),
        .point_value(point_value),
        .query_time_ms(query_time_ms),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .result_valid(result_valid),
        .result_curve(result_curve),
        .target_value(target_value),
        .clamped_flag(clamped_flag),
        .last(last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check(result_curve, target_value, clamped_flag, last);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_word(input logic m, input logic [1:0] c, input logic [3:0] p,
                             input logic [9:0] t, input logic signed [15:0] v,
                             input logic [26:0] q);
        int gap;
        gap = 0;
        if (sender_idle_pct > 0 && int'($urandom_range(0, 99)) < sender_idle_pct)
            gap = int'($urandom_range(1, 8));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= m;
        curve_index <= c;
        point_index <= p;
        point_time_min <= t;
        point_value <= v;
        query_time_ms <= q;
        do @(posedge clk); while (busy);
        board.note_word(m, c, p, t, v, q);
        if (m == MODE_LOAD)
            written_knots[c][p] = 1'b1;
        words_sent++;
    endtask

    task automatic load_point(input int c, input int p, input int t, input int v);
        send_word(MODE_LOAD, c[1:0], p[3:0], t[9:0], v[15:0],
                  27'($urandom_range(0, 27'h7FFFFFF)));
    endtask

    task automatic query_at(input longint q);
        send_word(MODE_QUERY, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                  10'($urandom_range(0, 1023)), 16'($urandom), q[26:0]);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (board.pending_results.size() != 0 || busy);
        repeat (4) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_curves(input int v);
        wait_idle();
        cfg_write_en <= 1'b1;
        cfg_write_data <= v[2:0];
        @(posedge clk);
        board.set_curves(v[2:0]);
        cfg_write_en <= 1'b0;
    endtask

    task automatic load_random_curve();
        int c;
        int n;
        int t;
        int step;
        int v;
        logic falling;
        c = $urandom_range(0, 3);
        n = $urandom_range(1, 16);
        falling = ($urandom_range(0, 7) == 0);
        t = falling ? $urandom_range(512, 1023) : $urandom_range(0, 300);
        for (int p = 0; p < n; p++)
        begin
            v = $urandom_range(0, 1) ? int'($urandom) : int'($urandom_range(0, 400)) - 200;
            load_point(c, p, t, v);
            step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1 + 700 / n);
            t = falling ? t - step : t + step;
            if (t > 1023)
                t = 1023;
            if (t < 0)
                t = 0;
        end
    endtask

    task automatic load_stray_point();
        int c;
        int f;
        c = $urandom_range(0, 3);
        f = 0;
        while (f < KNOTS_PER_CURVE && written_knots[c][f])
            f++;
        if (f > KNOTS_PER_CURVE - 1)
            f = KNOTS_PER_CURVE - 1;
        load_point(c, $urandom_range(0, f), $urandom_range(0, 1023), $urandom);
    endtask

    task automatic random_query();
        int pick;
        int c;
        int cnt;
        int jitter;
        longint q;
        pick = $urandom_range(0, 99);
        c = $urandom_range(0, 3);
        cnt = board.knot_count[c];
        jitter = int'($urandom_range(0, 2)) - 1;
        if (pick < 20)
            q = $urandom_range(0, 27'h7FFFFFF);
        else if (pick < 40 && cnt > 0)
            q = longint'(board.knot_time[c*KNOTS_PER_CURVE + $urandom_range(0, cnt - 1)])
                * MS_PER_MIN + jitter;
        else if (pick < 55)
            q = $urandom_range(0, 600000);
        else
            q = longint'($urandom_range(0, 1100)) * MS_PER_MIN + $urandom_range(0, 59999);
        if (q < 0)
            q = 0;
        query_at(q);
    endtask

    initial
    begin
        int target;
        int pick;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        query_at(0);
        write_curves(7);
        load_point(0, 0, 0, -32768);
        query_at(5);
        load_point(0, 1, 1023, 32767);
        load_point(0, 2, 1023, 100);
        load_point(1, 0, 5, 10);
        load_point(1, 1, 5, -20);
        load_point(1, 2, 9, 30);
        load_point(2, 0, 100, -32768);
        load_point(2, 1, 101, 32767);
        load_point(3, 0, 300, 1000);
        load_point(3, 1, 200, -3);
        query_at(0);
        query_at(1023 * MS_PER_MIN);
        query_at(27'h7FFFFFF);
        query_at(450000);
        write_curves(0);
        query_at(30000);
        write_curves(4);
        load_point(2, 0, 100, 32767);
        load_point(2, 1, 101, -32768);
        query_at(0);
        write_curves(1);
        query_at(12345678);

        for (int ph = 0; ph < 3; ph++)
        begin
            sender_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 55 : 0;
            write_curves((ph == 0) ? 4 : (ph == 1) ? 3 : 6);
            target = words_sent + 133;
            while (words_sent < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    load_random_curve();
                else if (pick < 85)
                    random_query();
                else
                    load_stray_point();
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/bci_pkg.sv
rtl/bci_divider.sv
rtl/bci_store.sv
rtl/breakpoint_curve_interpolator.sv
tb/breakpoint_curve_interpolator_test.sv
